// ===== sv/signed_decimal_text_formatter_assert.svh =====
// assertion macros shared by the formatter modules
`ifndef SIGNED_DECIMAL_TEXT_FORMATTER_ASSERT_SVH
`define SIGNED_DECIMAL_TEXT_FORMATTER_ASSERT_SVH

// condition holds at every clock edge outside reset
`define SDTF_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define SDTF_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define SDTF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sdtf_pkg.sv =====
// shared types, character codes and decade weights of the decimal formatter
`timescale 1ns / 1ps
`default_nettype none
package sdtf_pkg;

  localparam int VALUE_W = 32;
  localparam int CHAR_W  = 8;
  localparam int POS_W   = 4;
  localparam int WMUL_W  = 34;

  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] DIGIT_BASE = 8'd48;

  // character positions within a record
  localparam logic [POS_W-1:0] POS_SIGN        = 4'd0;
  localparam logic [POS_W-1:0] POS_FIRST_DIGIT = 4'd1;
  localparam logic [POS_W-1:0] POS_LAST_DIGIT  = 4'd10;
  localparam logic [POS_W-1:0] POS_TERM        = 4'd11;

  localparam logic [1:0] QUEUE_DEPTH = 2'd2;

  typedef struct packed {
    logic                negative;
    logic [VALUE_W-1:0]  magnitude;
    logic                newline;
  } entry_t;

  // k times the decade weight of digit idx, most significant digit first
  function automatic logic [WMUL_W-1:0] weight_times(logic [POS_W-1:0] idx,
                                                     logic [POS_W-1:0] k);
    logic [WMUL_W-1:0] kk;
    logic [WMUL_W-1:0] r;
    kk = {{(WMUL_W-POS_W){1'b0}}, k};
    case (idx)
      4'd0:    r = kk * 34'd1000000000;
      4'd1:    r = kk * 34'd100000000;
      4'd2:    r = kk * 34'd10000000;
      4'd3:    r = kk * 34'd1000000;
      4'd4:    r = kk * 34'd100000;
      4'd5:    r = kk * 34'd10000;
      4'd6:    r = kk * 34'd1000;
      4'd7:    r = kk * 34'd100;
      4'd8:    r = kk * 34'd10;
      4'd9:    r = kk;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/signed_decimal_text_formatter.sv =====
// Signed decimal text formatter: 32-bit signed integer in, 12 ASCII characters out.
// in_* channel: one request per integer; in_tdata carries the value, in_tuser
//   selects a line feed (1) or a space (0) as the record terminator.
// out_* channel: one character per transfer: sign, ten zero-padded digits
//   most significant first, then the terminator, which alone has out_tlast set.
// A request passes the front register and the queue, and its sign is then
//   registered on out_* (out_tvalid high); the other eleven characters follow
//   one per cycle while out_tready is high, the back end producing one
//   character per cycle (one restoring digit step per digit).
// A front register and a two-entry queue let requests be taken while the
//   previous record is still being sent.
// Reset (rst_n low, synchronous) empties the pipeline and the queue; any
//   record in progress is dropped. No clearing pass is needed.
// When out_tready is low the current character holds and the back end
//   stalls; the queue and front register then fill and in_tready drops.
`timescale 1ns / 1ps
`default_nettype none
module signed_decimal_text_formatter
  import sdtf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [VALUE_W-1:0] in_tdata,   // [31:0] value
  input  wire logic               in_tuser,   // [0] end_with_newline
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [CHAR_W-1:0]       out_tdata,  // [7:0] character
  output logic                    out_tlast
);

  logic   push_valid, push_ready;
  entry_t push_data;
  logic   q_valid, q_pop;
  entry_t q_data;

  sdtf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  sdtf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_data)
  );

  sdtf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

// ===== sv/sdtf_front.sv =====
// front end: takes requests, splits sign and magnitude, hands entries to the queue
`timescale 1ns / 1ps
`default_nettype none
module sdtf_front
  import sdtf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [VALUE_W-1:0] in_tdata,
  input  wire logic               in_tuser,
  output logic                    push_valid,
  input  wire logic               push_ready,
  output entry_t                  push_data
);

  logic   valid_r, valid_nxt;
  entry_t entry_r, entry_nxt;
  logic   take;

  always_comb begin
    in_tready = !valid_r || push_ready;
    take      = in_tvalid && in_tready;
    valid_nxt = take ? 1'b1 : (push_ready ? 1'b0 : valid_r);
    entry_nxt = entry_r;
    if (take) begin
      entry_nxt.negative  = in_tdata[VALUE_W-1];
      // unsigned negate so the most negative value keeps its magnitude
      entry_nxt.magnitude = in_tdata[VALUE_W-1] ? VALUE_W'(~in_tdata + 1'b1) : in_tdata;
      entry_nxt.newline   = in_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign push_valid = valid_r;
  assign push_data  = entry_r;

endmodule
`default_nettype wire

// ===== sv/sdtf_queue.sv =====
// two-entry queue between front and back end
`timescale 1ns / 1ps
`default_nettype none
`include "signed_decimal_text_formatter_assert.svh"
module sdtf_queue
  import sdtf_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push_valid,
  output logic        push_ready,
  input  wire entry_t push_data,
  output logic        pop_valid,
  input  wire logic   pop,
  output entry_t      pop_data
);

  entry_t     slot0_r, slot1_r;
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  always_comb begin
    push_ready = (count_r != QUEUE_DEPTH);
    pop_valid  = (count_r != 2'd0);
    do_push    = push_valid && push_ready;
    do_pop     = pop && pop_valid;
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
    pop_data   = rd_ptr_r ? slot1_r : slot0_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push && !wr_ptr_r) begin
      slot0_r <= push_data;
    end
    if (do_push && wr_ptr_r) begin
      slot1_r <= push_data;
    end
  end

  `SDTF_ASSERT_ALWAYS(a_count_max, count_r <= QUEUE_DEPTH, "queue count beyond depth")
  `SDTF_ASSERT_IMPLIES(a_ptr_match, count_r == 2'd0 || count_r == QUEUE_DEPTH,
    wr_ptr_r == rd_ptr_r, "queue pointers disagree with count")

endmodule
`default_nettype wire

// ===== sv/sdtf_back.sv =====
// back end: walks the twelve characters of a record into the output register
`timescale 1ns / 1ps
`default_nettype none
`include "signed_decimal_text_formatter_assert.svh"
module sdtf_back
  import sdtf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire entry_t            q_data,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [CHAR_W-1:0]      out_tdata,
  output logic                   out_tlast
);

  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [VALUE_W-1:0] rem_r, rem_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]  char_r, char_nxt;
  logic               last_r, last_nxt;
  logic               advance;
  logic [POS_W-1:0]   idx;
  logic [POS_W-1:0]   digit;
  logic [WMUL_W-1:0]  sub;

  // restoring digit step: largest multiple of the decade weight that fits
  always_comb begin
    idx   = POS_W'(pos_r - POS_FIRST_DIGIT);
    digit = '0;
    sub   = '0;
    for (int k = 1; k <= 9; k++) begin
      if ({2'b00, rem_r} >= weight_times(idx, POS_W'(k))) begin
        digit = POS_W'(k);
        sub   = weight_times(idx, POS_W'(k));
      end
    end
  end

  always_comb begin
    advance       = q_valid && (!out_valid_r || out_tready);
    out_valid_nxt = advance ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
    pos_nxt       = pos_r;
    rem_nxt       = rem_r;
    char_nxt      = char_r;
    last_nxt      = last_r;
    q_pop         = 1'b0;
    if (advance) begin
      pos_nxt  = POS_W'(pos_r + 1'b1);
      last_nxt = 1'b0;
      case (pos_r) inside
        POS_SIGN: begin
          char_nxt = q_data.negative ? CHAR_MINUS : CHAR_PLUS;
          rem_nxt  = q_data.magnitude;
        end
        [POS_FIRST_DIGIT:POS_LAST_DIGIT]: begin
          char_nxt = DIGIT_BASE + {{(CHAR_W-POS_W){1'b0}}, digit};
          rem_nxt  = rem_r - sub[VALUE_W-1:0];
        end
        POS_TERM: begin
          char_nxt = q_data.newline ? CHAR_LF : CHAR_SPACE;
          last_nxt = 1'b1;
          q_pop    = 1'b1;
          pos_nxt  = POS_SIGN;
        end
        default: begin
          pos_nxt = POS_SIGN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_SIGN;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = char_r;
  assign out_tlast  = last_r;

  `SDTF_ASSERT_ALWAYS(a_pos_range, pos_r <= POS_TERM, "character position out of range")
  `SDTF_ASSERT_IMPLIES(a_pop_at_end, q_pop, pos_r == POS_TERM,
    "queue popped before the record ended")
  `SDTF_ASSERT_IMPLIES(a_last_is_term, out_valid_r && last_r,
    char_r == CHAR_LF || char_r == CHAR_SPACE, "last character is not a terminator")
  `SDTF_ASSERT_NEXT(a_sign_first, advance && pos_r == POS_SIGN,
    (char_r == CHAR_PLUS || char_r == CHAR_MINUS) && !last_r,
    "record does not open with a sign")

endmodule
`default_nettype wire
